// ===== hdl/skts_pkg.sv =====
`timescale 1ns / 1ps

package skts_pkg;

  localparam int TABLE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 53;
  localparam int GRP_W       = 32;
  localparam int WID_W       = 32;
  localparam int ENT_W       = KEY_W + WID_W;

  localparam logic [WID_W-1:0] NEG_ONE_BITS   = 32'hBF80_0000;
  localparam logic [20:0]      MAX_CODE_POINT = 21'h10_FFFF;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_POINT = 2'd1;
  localparam logic [1:0] REQ_GROUP = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] entry_index;
    logic [15:0] font_id;
    logic [15:0] size_px;
    logic [20:0] code_point;
    logic [31:0] width_in;
  } in_req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] width_out;
    logic [15:0] first_index;
    logic [16:0] match_count;
  } out_res_t;

  localparam out_res_t RES_NONE = '{
    found:       1'b0,
    width_out:   NEG_ONE_BITS,
    first_index: 16'd0,
    match_count: 17'd0
  };

endpackage

// ===== hdl/skts_ram.sv =====
`timescale 1ns / 1ps

module skts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sorted_key_table_search_unit.sv =====
// A write goes straight to ST_DONE. A point lookup runs binary-search probes (at
// most ceil(log2(n+1)) probes), each ST_PT_RD then ST_PT_CMP. A group lookup runs the
// lower-bound probes, then scans the group's entries and the entry past it, if any.
// One request in flight; the next is taken once the result sits in the output
// register. Probes are bound by the single read port of the entry RAM.
// Reset (sync, active low) clears control and entry_count; table RAM is not cleared.
`timescale 1ns / 1ps

module sorted_key_table_search_unit
  import skts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_req_t            in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output out_res_t           out_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [16:0]        cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PT_RD  = 3'd1;
  localparam logic [2:0] ST_PT_CMP = 3'd2;
  localparam logic [2:0] ST_LB_RD  = 3'd3;
  localparam logic [2:0] ST_LB_CMP = 3'd4;
  localparam logic [2:0] ST_SC_RD  = 3'd5;
  localparam logic [2:0] ST_SC_CMP = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]       state_r, state_nxt;
  in_req_t          req_r, req_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0] end_r, end_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  out_res_t         res_r, res_nxt;
  out_res_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [16:0]      entry_count_r;

  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  logic [CNT_W-1:0] live_n;
  logic [CNT_W-1:0] mid_calc;
  logic [CNT_W-1:0] lo_new;
  logic [CNT_W-1:0] hi_new;
  logic [CNT_W-1:0] end_inc;
  logic [CNT_W-1:0] cnt;
  logic [KEY_W-1:0] rd_key;
  logic [KEY_W-1:0] want_key;
  logic [GRP_W-1:0] want_grp;
  logic             finish;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  assign live_n   = (32'(entry_count_r) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                             : CNT_W'(entry_count_r);
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_key   = ram_rdata[ENT_W-1:WID_W];
  assign want_key = {req_r.font_id, req_r.size_px, req_r.code_point};
  assign want_grp = {req_r.font_id, req_r.size_px};

  assign ram_waddr = ADDR_W'(in_req.entry_index);
  assign ram_wdata = {in_req.font_id, in_req.size_px, in_req.code_point, in_req.width_in};
  assign ram_raddr = (state_r == ST_SC_RD) ? ADDR_W'(end_r) : ADDR_W'(mid_calc);

  skts_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    end_nxt       = end_r;
    n_nxt         = n_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    lo_new        = lo_r;
    hi_new        = hi_r;
    end_inc       = end_r + CNT_W'(1);
    cnt           = '0;
    finish        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req;
          lo_nxt  = '0;
          hi_nxt  = live_n;
          n_nxt   = live_n;
          res_nxt = RES_NONE;
          case (in_req.req_type)
            REQ_WRITE: begin
              ram_we    = (32'(in_req.entry_index) < 32'(TABLE_DEPTH));
              state_nxt = ST_DONE;
            end
            REQ_POINT: begin
              if (live_n == '0 || in_req.code_point > MAX_CODE_POINT) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_PT_RD;
              end
            end
            REQ_GROUP: begin
              state_nxt = (live_n == '0) ? ST_DONE : ST_LB_RD;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_PT_RD: begin
        mid_nxt   = mid_calc;
        state_nxt = ST_PT_CMP;
      end
      ST_PT_CMP: begin
        if (rd_key < want_key) begin
          lo_new = mid_r + CNT_W'(1);
        end else if (rd_key > want_key) begin
          hi_new = mid_r;
        end else begin
          res_nxt.found     = 1'b1;
          res_nxt.width_out = ram_rdata[WID_W-1:0];
        end
        lo_nxt = lo_new;
        hi_nxt = hi_new;
        if (rd_key == want_key || lo_new >= hi_new) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PT_RD;
        end
      end
      ST_LB_RD: begin
        mid_nxt   = mid_calc;
        state_nxt = ST_LB_CMP;
      end
      ST_LB_CMP: begin
        if (rd_key[KEY_W-1:KEY_W-GRP_W] < want_grp) begin
          lo_new = mid_r + CNT_W'(1);
        end else begin
          hi_new = mid_r;
        end
        lo_nxt = lo_new;
        hi_nxt = hi_new;
        if (lo_new < hi_new) begin
          state_nxt = ST_LB_RD;
        end else begin
          end_nxt   = lo_new;
          state_nxt = (lo_new < n_r) ? ST_SC_RD : ST_DONE;
        end
      end
      ST_SC_RD: begin
        state_nxt = ST_SC_CMP;
      end
      ST_SC_CMP: begin
        if (rd_key[KEY_W-1:KEY_W-GRP_W] == want_grp) begin
          end_nxt = end_inc;
          if (end_inc < n_r) begin
            state_nxt = ST_SC_RD;
          end else begin
            cnt    = end_inc - lo_r;
            finish = 1'b1;
          end
        end else begin
          cnt    = end_r - lo_r;
          finish = 1'b1;
        end
        if (finish) begin
          state_nxt = ST_DONE;
          if (cnt != '0) begin
            res_nxt.found       = 1'b1;
            res_nxt.first_index = 16'(lo_r);
            res_nxt.match_count = 17'(cnt);
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      entry_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        entry_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    end_r <= end_nxt;
    n_r   <= n_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

endmodule

// ===== hdl/skts_checker.sv =====
`timescale 1ns / 1ps

module skts_checker
  import skts_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_res_t out_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.found |->
      out_res.width_out == NEG_ONE_BITS && out_res.first_index == 16'd0 &&
      out_res.match_count == 17'd0)
    else $error("miss result carries data");

  a_group_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.match_count != 17'd0 |->
      out_res.found && out_res.width_out == NEG_ONE_BITS)
    else $error("group result carries a width");

endmodule

bind sorted_key_table_search_unit skts_checker u_skts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);

// ===== bench/tb_sorted_key_table_search_unit.sv =====
`timescale 1ns / 1ps

module tb_sorted_key_table_search_unit;
  import skts_pkg::*;

  localparam int          CLK_HALF       = 6;
  localparam int          RESET_CYCLES   = 12;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          END_HOLD       = 40;
  localparam int          MAX_REPORTS    = 40;
  localparam int          MODE_ITEMS     = 280;
  localparam int          GRP_LO         = KEY_W - GRP_W;
  localparam int          RES_W          = $bits(out_res_t);
  localparam logic [1:0]  REQ_UNUSED     = 2'd3;
  localparam logic [16:0] COUNT_MAX      = 17'h1_FFFF;

  typedef struct {
    bit          cfg_row;
    logic [16:0] cfg_value;
    in_req_t     req;
    bit          typed;
    out_res_t    res;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_req_t     in_req    = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_res_t    out_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data  = '0;

  logic [KEY_W-1:0] key_mirror   [TABLE_DEPTH];
  logic [WID_W-1:0] width_mirror [TABLE_DEPTH];
  logic [16:0]      count_mirror = '0;
  out_res_t         pending_res [$];
  dir_row_t         dir_tbl [$];
  bit               full_written [int unsigned];
  int unsigned      src_idle_pct = 0;
  int unsigned      snk_idle_pct = 0;
  int unsigned      err_count    = 0;
  int unsigned      idle_cycles  = 0;
  int unsigned      mode_items   = 0;

  always #CLK_HALF clk = ~clk;

  sorted_key_table_search_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic out_res_t predict_search(input in_req_t r);
    out_res_t         res;
    logic [KEY_W-1:0] want;
    logic [GRP_W-1:0] want_grp;
    int unsigned      live, lo, hi, mid, stop;
    res      = RES_NONE;
    live     = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : count_mirror;
    want     = {r.font_id, r.size_px, r.code_point};
    want_grp = {r.font_id, r.size_px};
    lo       = 0;
    hi       = live;
    case (r.req_type)
      REQ_WRITE: begin
        key_mirror[r.entry_index]   = want;
        width_mirror[r.entry_index] = r.width_in;
      end
      REQ_POINT: begin
        if (r.code_point <= MAX_CODE_POINT) begin
          while (lo < hi && !res.found) begin
            mid = lo + (hi - lo) / 2;
            if (key_mirror[mid] < want) begin
              lo = mid + 1;
            end else if (key_mirror[mid] > want) begin
              hi = mid;
            end else begin
              res.found     = 1'b1;
              res.width_out = width_mirror[mid];
            end
          end
        end
      end
      REQ_GROUP: begin
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (key_mirror[mid][KEY_W-1:GRP_LO] < want_grp) lo = mid + 1;
          else hi = mid;
        end
        stop = lo;
        while (stop < live && key_mirror[stop][KEY_W-1:GRP_LO] == want_grp) stop++;
        if (stop != lo) begin
          res.found       = 1'b1;
          res.first_index = 16'(lo);
          res.match_count = 17'(stop - lo);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [20:0] random_cp();
    if ($urandom_range(0, 9) == 0) return 21'($urandom);
    return 21'($urandom_range(0, MAX_CODE_POINT));
  endfunction

  function automatic in_req_t random_req();
    in_req_t r;
    r.req_type    = 2'($urandom_range(0, 3));
    r.entry_index = 16'($urandom);
    r.font_id     = 16'($urandom);
    r.size_px     = 16'($urandom);
    r.code_point  = random_cp();
    r.width_in    = $urandom;
    return r;
  endfunction

  // full-depth table layout: pairs of entries per font/size group
  function automatic logic [KEY_W-1:0] full_key(input int unsigned i);
    return {16'(i >> 3), 16'((i >> 1) & 3), 21'(i & 1)};
  endfunction

  function automatic void add_req(input in_req_t r, input bit typed, input out_res_t res);
    dir_row_t row;
    row = '{1'b0, 17'd0, r, typed, res};
    dir_tbl.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [16:0] value);
    dir_row_t row;
    row = '{1'b1, value, in_req_t'('0), 1'b0, RES_NONE};
    dir_tbl.push_back(row);
  endfunction

  task automatic report_mismatch(input string field, input logic [RES_W-1:0] got,
                                 input logic [RES_W-1:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, field, got, want);
  endtask

  task automatic send_req(input in_req_t r, input bit typed, input out_res_t typed_res);
    out_res_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pred = predict_search(r);
    pending_res.push_back(typed ? typed_res : pred);
  endtask

  // entry_count only changes with nothing in flight
  task automatic write_count(input logic [16:0] value);
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid    <= 1'b0;
    count_mirror  = value;
  endtask

  // load a sorted table with random keys, then mostly well-aimed lookups
  task automatic run_segment();
    in_req_t          r;
    logic [KEY_W-1:0] acc;
    logic [KEY_W:0]   sum;
    int unsigned      n, looks, j, pick, live;
    pick = $urandom_range(0, 99);
    if (pick < 60) n = $urandom_range(1, 16);
    else if (pick < 92) n = $urandom_range(17, 100);
    else n = $urandom_range(101, 400);
    acc = {21'($urandom), $urandom};
    for (int i = 0; i < n; i++) begin
      if (i != 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)
          sum = acc + $urandom_range(0, 4);
        else if (pick < 85)
          sum = {33'(acc[KEY_W-1:GRP_LO]) + 33'($urandom_range(1, 3)), random_cp()};
        else
          sum = {17'(acc[KEY_W-1:KEY_W-16]) + 17'($urandom_range(1, 2)), 16'($urandom),
                 random_cp()};
        if (!sum[KEY_W]) acc = sum[KEY_W-1:0];
      end
      r             = random_req();
      r.req_type    = REQ_WRITE;
      r.entry_index = 16'(i);
      {r.font_id, r.size_px, r.code_point} = acc;
      send_req(r, 1'b0, RES_NONE);
    end
    live = ($urandom_range(0, 99) < 85) ? n : $urandom_range(0, n);
    write_count(17'(live));
    looks = $urandom_range(12, 40);
    repeat (looks) begin
      r    = random_req();
      j    = $urandom_range(0, n - 1);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        r.req_type = REQ_POINT;
        {r.font_id, r.size_px, r.code_point} = key_mirror[j];
      end else if (pick < 55) begin
        r.req_type = REQ_POINT;
        {r.font_id, r.size_px, r.code_point} = key_mirror[j] ^ 53'd1;
      end else if (pick < 85) begin
        r.req_type = REQ_GROUP;
        {r.font_id, r.size_px} = key_mirror[j][KEY_W-1:GRP_LO] +
                                 32'($urandom_range(0, 3) == 0);
      end else if (pick < 90) begin
        // random key into one of the n loaded entries can leave the table unsorted
        r.req_type    = REQ_WRITE;
        r.entry_index = 16'($urandom_range(0, n - 1));
      end
      send_req(r, 1'b0, RES_NONE);
    end
    mode_items += n + looks;
  endtask

  task automatic write_full(input int unsigned i);
    in_req_t r;
    if (!full_written.exists(i)) begin
      r                                    = random_req();
      r.req_type                           = REQ_WRITE;
      r.entry_index                        = 16'(i);
      {r.font_id, r.size_px, r.code_point} = full_key(i);
      send_req(r, 1'b0, RES_NONE);
      full_written[i] = 1'b1;
    end
  endtask

  // writes the entries a lookup on the full-depth table reads, and no others
  task automatic fill_path(input logic [KEY_W-1:0] want, input bit grp);
    logic [KEY_W-1:0] k;
    int unsigned      lo, hi, mid, stop;
    lo = 0;
    hi = TABLE_DEPTH;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      k   = full_key(mid);
      write_full(mid);
      if (grp ? (k[KEY_W-1:GRP_LO] < want[KEY_W-1:GRP_LO]) : (k < want)) lo = mid + 1;
      else if (grp || k > want) hi = mid;
      else hi = lo;
    end
    if (grp) begin
      stop = lo;
      while (stop < TABLE_DEPTH) begin
        write_full(stop);
        k = full_key(stop);
        if (k[KEY_W-1:GRP_LO] != want[KEY_W-1:GRP_LO]) break;
        stop++;
      end
    end
  endtask

  task automatic probe_full_table(input int unsigned looks);
    in_req_t     r;
    int unsigned j;
    bit          grp;
    repeat (looks) begin
      r = random_req();
      case ($urandom_range(0, 7))
        0:       j = 0;
        1:       j = TABLE_DEPTH - 1;
        default: j = $urandom_range(0, TABLE_DEPTH - 1);
      endcase
      {r.font_id, r.size_px, r.code_point} = full_key(j);
      grp = 1'b0;
      case ($urandom_range(0, 2))
        0: begin
          r.req_type = REQ_POINT;
        end
        1: begin
          r.req_type   = REQ_POINT;
          r.code_point = 21'd2;
        end
        default: begin
          r.req_type = REQ_GROUP;
          grp        = 1'b1;
        end
      endcase
      fill_path({r.font_id, r.size_px, r.code_point}, grp);
      send_req(r, 1'b0, RES_NONE);
    end
  endtask

  always @(posedge clk) begin : res_check
    out_res_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result", out_res, '0);
      end else begin
        want = pending_res.pop_front();
        if (out_res.found !== want.found)
          report_mismatch("found", RES_W'(out_res.found), RES_W'(want.found));
        if (out_res.width_out !== want.width_out)
          report_mismatch("width_out", RES_W'(out_res.width_out), RES_W'(want.width_out));
        if (out_res.first_index !== want.first_index)
          report_mismatch("first_index", RES_W'(out_res.first_index),
                          RES_W'(want.first_index));
        if (out_res.match_count !== want.match_count)
          report_mismatch("match_count", RES_W'(out_res.match_count),
                          RES_W'(want.match_count));
      end
    end
    out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL sorted_key_table_search_unit");
      $finish;
    end
  end

  initial begin
    // directed rows, starting with the empty table after reset
    add_req(in_req_t'{REQ_POINT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 21'h10_FFFF, 32'hFFFF_FFFF},
            1'b1, RES_NONE);
    add_req(in_req_t'{REQ_GROUP, 16'h0, 16'h0, 16'h0, 21'h0, 32'h0}, 1'b1, RES_NONE);
    add_req(in_req_t'{REQ_UNUSED, 16'h8001, 16'h0, 16'h0, 21'h0, 32'h3F80_0000},
            1'b1, RES_NONE);
    add_req(in_req_t'{REQ_WRITE, 16'd0, 16'h0, 16'h0, 21'h0, 32'h0}, 1'b1, RES_NONE);
    add_req(in_req_t'{REQ_WRITE, 16'd1, 16'h0, 16'h0, 21'h1, 32'h3F80_0000}, 1'b1, RES_NONE);
    add_req(in_req_t'{REQ_WRITE, 16'd2, 16'h5, 16'h7, 21'h10_FFFF, 32'hFFFF_FFFF},
            1'b1, RES_NONE);
    add_req(in_req_t'{REQ_WRITE, 16'd3, 16'h5, 16'h7, 21'h1F_FFFF, 32'h1234_5678},
            1'b1, RES_NONE);
    add_req(in_req_t'{REQ_WRITE, 16'd4, 16'hFFFF, 16'hFFFF, 21'h10_FFFF, 32'h4120_0000},
            1'b1, RES_NONE);
    add_req(in_req_t'{REQ_POINT, 16'h0, 16'h0, 16'h0, 21'h0, 32'h0}, 1'b1, RES_NONE);
    add_cfg(17'd5);
    add_req(in_req_t'{REQ_POINT, 16'hFFFF, 16'h0, 16'h0, 21'h0, 32'hFFFF_FFFF},
            1'b1, out_res_t'{1'b1, 32'h0, 16'd0, 17'd0});
    add_req(in_req_t'{REQ_POINT, 16'h0, 16'hFFFF, 16'hFFFF, 21'h10_FFFF, 32'h0},
            1'b1, out_res_t'{1'b1, 32'h4120_0000, 16'd0, 17'd0});
    add_req(in_req_t'{REQ_POINT, 16'h0, 16'h5, 16'h7, 21'h1F_FFFF, 32'h0}, 1'b1, RES_NONE);
    add_req(in_req_t'{REQ_POINT, 16'h0, 16'h5, 16'h7, 21'h10_FFFE, 32'h0}, 1'b0, RES_NONE);
    add_req(in_req_t'{REQ_GROUP, 16'h0, 16'h0, 16'h0, 21'h1F_FFFF, 32'h0},
            1'b1, out_res_t'{1'b1, NEG_ONE_BITS, 16'd0, 17'd2});
    add_req(in_req_t'{REQ_GROUP, 16'h0, 16'h5, 16'h7, 21'h0, 32'h0},
            1'b1, out_res_t'{1'b1, NEG_ONE_BITS, 16'd2, 17'd2});
    add_req(in_req_t'{REQ_GROUP, 16'h0, 16'hFFFF, 16'hFFFF, 21'h0, 32'h0},
            1'b1, out_res_t'{1'b1, NEG_ONE_BITS, 16'd4, 17'd1});
    add_req(in_req_t'{REQ_GROUP, 16'h0, 16'h3, 16'h3, 21'h0, 32'h0}, 1'b0, RES_NONE);
    add_req(in_req_t'{REQ_UNUSED, 16'h0, 16'h0, 16'h0, 21'h0, 32'h0}, 1'b1, RES_NONE);
    add_cfg(17'd1);
    add_req(in_req_t'{REQ_GROUP, 16'h0, 16'h0, 16'h0, 21'h0, 32'h0}, 1'b0, RES_NONE);
    add_req(in_req_t'{REQ_WRITE, 16'd0, 16'h9, 16'h9, 21'h9, 32'h0}, 1'b1, RES_NONE);
    add_cfg(17'd5);
    add_req(in_req_t'{REQ_POINT, 16'h0, 16'h0, 16'h0, 21'h1, 32'h0}, 1'b0, RES_NONE);
    add_req(in_req_t'{REQ_GROUP, 16'h0, 16'h5, 16'h7, 21'h0, 32'h0}, 1'b0, RES_NONE);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 19;
    snk_idle_pct = 73;
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].cfg_row) write_count(dir_tbl[i].cfg_value);
      else send_req(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].res);
    end
    mode_items = 0;
    while (mode_items < MODE_ITEMS) run_segment();

    src_idle_pct = 73;
    snk_idle_pct = 19;
    mode_items   = 0;
    while (mode_items < MODE_ITEMS) run_segment();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    mode_items   = 0;
    while (mode_items < MODE_ITEMS) run_segment();

    // full-depth table; only the entries on each lookup's path are loaded
    write_count(COUNT_MAX);
    probe_full_table(12);
    write_count(17'(TABLE_DEPTH));
    probe_full_table(8);

    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (END_HOLD) @(posedge clk);
    if (err_count == 0 && pending_res.size() == 0)
      $display("PASS sorted_key_table_search_unit");
    else
      $display("FAIL sorted_key_table_search_unit");
    $finish;
  end

endmodule
